// ===== rtl/core/rhp_pkg.sv =====
`timescale 1ns / 1ps

package rhp_pkg;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_DISCARD = 2'd2;

  localparam logic [7:0] P_MASK   = 8'h04;
  localparam logic [7:0] V_MASK   = 8'h02;
  localparam logic [7:0] PLEN_MSB = 8'h01;
  localparam int         PLEN_LSB_SHIFT = 3;
  localparam int         PLEN_MSB_POS   = 5;
  localparam logic [6:0] POS_MAX  = 7'd127;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_first;
    logic       packet_last;
    logic       rtp_marker;
    logic       discontinuity;
  } rhp_in_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  out_byte;
    logic [15:0] frame_length;
    logic        frame_overflow;
    logic        run_last;
  } rhp_out_t;

  // Everything one input byte asks the back end to emit, in emit order:
  // discard, zero bytes, body byte, frame commit.
  typedef struct packed {
    logic        discard;
    logic [1:0]  zero_cnt;
    logic        body;
    logic [7:0]  body_byte;
    logic        done;
    logic [15:0] done_len;
    logic        done_ovf;
  } rhp_cmd_t;

  typedef struct packed {
    logic     valid;
    rhp_cmd_t cmd;
  } rhp_q_head_t;

endpackage

// ===== rtl/core/rtp_h263p_payload_depacketizer_core.sv =====
`timescale 1ns / 1ps
// Channel   Handshake                    Payload
// item      item_valid / item_ready      item   (rhp_pkg::rhp_in_t)
// result    result_valid / result_ready  result (rhp_pkg::rhp_out_t)
//
// The front end takes one payload byte per cycle while its two-entry request
// queue has room; the back end emits one result per cycle while result_ready
// is high, so a byte with up to three results holds it until all are taken.
// An accepted byte is registered in the queue and then in the back end.
// Reset (rst, synchronous) empties the queue and restores the parser state.
// A stalled result side backs up into the queue and then drops item_ready.

module rtp_h263p_payload_depacketizer_core #(
  parameter int LENGTH_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  rhp_pkg::rhp_in_t  item,
  output logic              result_valid,
  input  logic              result_ready,
  output rhp_pkg::rhp_out_t result
);
  import rhp_pkg::*;

  logic        push;
  rhp_cmd_t    push_cmd;
  logic        q_full;
  logic        pop;
  rhp_q_head_t head;

  rhp_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  rhp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (pop),
    .head    (head)
  );

  rhp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule

// ===== rtl/core/rhp_front.sv =====
`timescale 1ns / 1ps

module rhp_front #(
  parameter int LENGTH_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  rhp_pkg::rhp_in_t item,
  input  logic            q_full,
  output logic            push,
  output rhp_pkg::rhp_cmd_t push_cmd
);
  import rhp_pkg::*;

  localparam int LB = LENGTH_BITS;
  localparam logic [LB:0] LEN_MAX = {1'b0, {LB{1'b1}}};

  logic [6:0]    byte_position;
  logic          picture_start_bit;
  logic          vrc_present;
  logic [5:0]    extra_header_length;
  logic          waiting_for_start;
  logic          packet_dropped;
  logic [LB-1:0] bytes_in_frame;
  logic          length_saturated;

  logic          accept;
  logic [6:0]    p;
  logic          dropped;
  logic          disc_ev;
  logic          waiting_eff;
  logic [LB-1:0] cnt_base;
  logic          sat_base;
  logic          psb_next;
  logic          vrc_next;
  logic [5:0]    ehl_next;
  logic [6:0]    hdr;
  logic [6:0]    hdr_m1;
  logic          at_hdr_end;
  logic          zeros;
  logic          body;
  logic          drop_now;
  logic          done;
  logic [1:0]    inc;
  logic [LB:0]   sum;
  logic          over;
  logic [LB-1:0] cnt_new;
  logic          sat_new;
  logic [LB+15:0] len_wide;

  assign item_ready = !q_full;
  assign accept     = item_valid && item_ready;

  always_comb begin
    disc_ev     = item.packet_first && item.discontinuity;
    p           = item.packet_first ? 7'd0 : byte_position;
    dropped     = item.packet_first ? 1'b0 : packet_dropped;
    waiting_eff = disc_ev ? 1'b1 : waiting_for_start;
    cnt_base    = disc_ev ? '0 : bytes_in_frame;
    sat_base    = disc_ev ? 1'b0 : length_saturated;

    psb_next = picture_start_bit;
    vrc_next = vrc_present;
    ehl_next = extra_header_length;
    if (p == 7'd0) begin
      psb_next = (item.data_byte & P_MASK) != 8'd0;
      vrc_next = (item.data_byte & V_MASK) != 8'd0;
      ehl_next = {((item.data_byte & PLEN_MSB) != 8'd0), 5'd0};
    end else if (p == 7'd1) begin
      ehl_next = {extra_header_length[PLEN_MSB_POS],
                  item.data_byte[7:PLEN_LSB_SHIFT]};
    end

    hdr    = 7'd2 + {6'd0, vrc_next} + {1'b0, ehl_next};
    hdr_m1 = hdr - 7'd1;

    at_hdr_end = !dropped && (p != 7'd0) && (p == hdr_m1);
    body       = !dropped && (p != 7'd0) && (p >= hdr);
    zeros      = at_hdr_end && psb_next;
    drop_now   = at_hdr_end && !psb_next && waiting_eff;
    done       = !dropped && item.packet_last && !drop_now && (p != 7'd0) &&
                 (p >= hdr_m1) && item.rtp_marker;

    inc     = zeros ? 2'd2 : (body ? 2'd1 : 2'd0);
    sum     = {1'b0, cnt_base} + {{(LB-1){1'b0}}, inc};
    over    = sum > LEN_MAX;
    cnt_new = over ? LEN_MAX[LB-1:0] : sum[LB-1:0];
    sat_new = sat_base || over;
    len_wide = {16'd0, cnt_new};

    push_cmd.discard   = disc_ev;
    push_cmd.zero_cnt  = zeros ? 2'd2 : 2'd0;
    push_cmd.body      = body;
    push_cmd.body_byte = item.data_byte;
    push_cmd.done      = done;
    push_cmd.done_len  = len_wide[15:0];
    push_cmd.done_ovf  = sat_new;
  end

  assign push = accept && (disc_ev || zeros || body || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= '0;
      picture_start_bit   <= 1'b0;
      vrc_present         <= 1'b0;
      extra_header_length <= '0;
      waiting_for_start   <= 1'b1;
      packet_dropped      <= 1'b0;
      bytes_in_frame      <= '0;
      length_saturated    <= 1'b0;
    end else if (accept) begin
      if (!dropped) begin
        picture_start_bit   <= psb_next;
        vrc_present         <= vrc_next;
        extra_header_length <= ehl_next;
      end
      waiting_for_start <= zeros ? 1'b0 : waiting_eff;
      if (done) begin
        bytes_in_frame   <= '0;
        length_saturated <= 1'b0;
      end else begin
        bytes_in_frame   <= cnt_new;
        length_saturated <= sat_new;
      end
      if (item.packet_last) begin
        byte_position  <= '0;
        packet_dropped <= 1'b0;
      end else begin
        byte_position  <= (p < POS_MAX) ? p + 7'd1 : p;
        packet_dropped <= dropped || drop_now;
      end
    end
  end

endmodule

// ===== rtl/core/rhp_queue.sv =====
`timescale 1ns / 1ps

module rhp_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rhp_pkg::rhp_cmd_t     push_cmd,
  output logic                  full,
  input  logic                  pop,
  output rhp_pkg::rhp_q_head_t  head
);
  import rhp_pkg::*;

  rhp_cmd_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = count == 2'd2;
  assign head.valid = count != 2'd0;
  assign head.cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/core/rhp_back.sv =====
`timescale 1ns / 1ps

module rhp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  rhp_pkg::rhp_q_head_t head,
  output logic                 pop,
  output logic                 result_valid,
  input  logic                 result_ready,
  output rhp_pkg::rhp_out_t    result
);
  import rhp_pkg::*;

  rhp_cmd_t cur;
  logic     cur_valid;
  rhp_cmd_t cur_next;
  logic     is_last;
  logic     taken;

  assign result_valid = cur_valid;
  assign taken        = cur_valid && result_ready;

  // The head of the current request picks the result; accepting it retires
  // that one event from the request.
  always_comb begin
    result   = '0;
    cur_next = cur;
    is_last  = 1'b1;
    if (cur.discard) begin
      result.event_kind = KIND_DISCARD;
      is_last           = !((cur.zero_cnt != 2'd0) || cur.body || cur.done);
      cur_next.discard  = 1'b0;
    end else if (cur.zero_cnt != 2'd0) begin
      result.event_kind = KIND_BYTE;
      is_last           = (cur.zero_cnt == 2'd1) && !cur.body && !cur.done;
      cur_next.zero_cnt = cur.zero_cnt - 2'd1;
    end else if (cur.body) begin
      result.event_kind = KIND_BYTE;
      result.out_byte   = cur.body_byte;
      is_last           = !cur.done;
      cur_next.body     = 1'b0;
    end else begin
      result.event_kind     = KIND_DONE;
      result.frame_length   = cur.done_len;
      result.frame_overflow = cur.done_ovf;
      is_last               = 1'b1;
      cur_next.done         = 1'b0;
    end
    result.run_last = is_last;
  end

  assign pop = head.valid && (!cur_valid || (taken && is_last));

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.cmd;
    end else if (taken) begin
      cur <= cur_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (taken && is_last) begin
      cur_valid <= 1'b0;
    end
  end

endmodule

// ===== tb/sv/rtp_h263p_payload_depacketizer_core_tb.sv =====
`timescale 1ns / 1ps

module rtp_h263p_payload_depacketizer_core_tb;
  import rhp_pkg::*;

  localparam int QUIET_LIMIT    = 2000;
  localparam int MAX_REPORTS    = 40;
  localparam int RANDOM_BYTES   = 120;
  localparam int CALM_BYTES     = 40;
  localparam int IDLE_PCT       = 37;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     item_valid = 1'b0;
  logic     item_ready;
  rhp_in_t  item = '0;
  logic     result_valid;
  logic     result_ready = 1'b0;
  rhp_out_t result;

  // Parser and frame state of the depacketizer as the testbench tracks it.
  logic [6:0]  pkt_pos = '0;
  logic        pic_start = 1'b0;
  logic        vrc_flag = 1'b0;
  logic [5:0]  plen = '0;
  logic        await_picture = 1'b1;
  logic        pkt_skip = 1'b0;
  logic [15:0] frame_count = '0;
  logic        frame_sat = 1'b0;

  rhp_out_t   expected_results[$];
  rhp_out_t   oldest;
  logic [7:0] pkt_buf[$];

  int stall_pct = IDLE_PCT;
  int mismatches = 0;
  int bytes_sent = 0;
  int results_checked = 0;
  int commits_seen = 0;
  int saturated_commits = 0;
  int discards_seen = 0;

  rtp_h263p_payload_depacketizer_core DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_REPORTS) begin
      $display("MISMATCH result %0d: %s got %0d expected %0d",
               results_checked, what, got, want);
    end
    mismatches++;
  endtask

  function automatic rhp_out_t frame_event(input logic [1:0] kind, input logic [7:0] b,
                                           input logic [15:0] len, input logic ovf);
    rhp_out_t ev;
    ev.event_kind = kind;
    ev.out_byte = b;
    ev.frame_length = len;
    ev.frame_overflow = ovf;
    ev.run_last = 1'b0;
    return ev;
  endfunction

  function automatic rhp_in_t payload_byte(input logic [7:0] b, input logic first,
                                           input logic last, input logic marker,
                                           input logic disc);
    rhp_in_t req;
    req.data_byte = b;
    req.packet_first = first;
    req.packet_last = last;
    req.rtp_marker = marker;
    req.discontinuity = disc;
    return req;
  endfunction

  function automatic void count_frame_byte();
    if (frame_count == 16'hFFFF) begin
      frame_sat = 1'b1;
    end else begin
      frame_count++;
    end
  endfunction

  // Works out every result one accepted payload byte causes, in emit order.
  task automatic predict_results(input rhp_in_t req);
    rhp_out_t run[$];
    int pos;
    int hdr_len;
    if (req.packet_first) begin
      pkt_pos = '0;
      pkt_skip = 1'b0;
      if (req.discontinuity) begin
        run.push_back(frame_event(KIND_DISCARD, 8'h00, 16'h0000, 1'b0));
        frame_count = '0;
        frame_sat = 1'b0;
        await_picture = 1'b1;
      end
    end
    pos = int'(pkt_pos);
    if (!pkt_skip) begin
      if (pos == 0) begin
        pic_start = (req.data_byte & P_MASK) != 0;
        vrc_flag = (req.data_byte & V_MASK) != 0;
        plen = 6'((req.data_byte & PLEN_MSB) << PLEN_MSB_POS);
      end else if (pos == 1) begin
        plen = {plen[5], 5'(req.data_byte >> PLEN_LSB_SHIFT)};
      end
      hdr_len = 2 + int'(vrc_flag) + int'(plen);
      if (pos >= 1 && pos == hdr_len - 1) begin
        if (pic_start) begin
          await_picture = 1'b0;
          repeat (2) begin
            run.push_back(frame_event(KIND_BYTE, 8'h00, 16'h0000, 1'b0));
            count_frame_byte();
          end
        end else if (await_picture) begin
          pkt_skip = 1'b1;
        end
      end else if (pos >= 1 && pos >= hdr_len) begin
        run.push_back(frame_event(KIND_BYTE, req.data_byte, 16'h0000, 1'b0));
        count_frame_byte();
      end
      // A packet shorter than its header commits nothing.
      if (req.packet_last && !pkt_skip && pos >= 1 && pos >= hdr_len - 1 &&
          req.rtp_marker) begin
        run.push_back(frame_event(KIND_DONE, 8'h00, frame_count, frame_sat));
        frame_count = '0;
        frame_sat = 1'b0;
      end
    end
    if (req.packet_last) begin
      pkt_pos = '0;
      pkt_skip = 1'b0;
    end else if (pkt_pos < POS_MAX) begin
      pkt_pos++;
    end
    if (run.size() > 0) begin
      run[run.size() - 1].run_last = 1'b1;
    end
    foreach (run[i]) begin
      expected_results.push_back(run[i]);
    end
  endtask

  task automatic send_byte(input rhp_in_t req);
    while (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item <= req;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    bytes_sent++;
    predict_results(req);
  endtask

  // Sends pkt_buf as one packet; marker and discontinuity carry noise where unused.
  task automatic send_packet(input logic marker, input logic disc);
    int last_idx;
    last_idx = pkt_buf.size() - 1;
    foreach (pkt_buf[i]) begin
      send_byte(payload_byte(pkt_buf[i], i == 0, i == last_idx,
                             (i == last_idx) ? marker : 1'($urandom),
                             (i == 0) ? disc : 1'($urandom)));
    end
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic test_waiting_drop();
    pkt_buf = '{8'h00, 8'h00, 8'hAA, 8'hBB};
    send_packet(1'b1, 1'b0);
    pkt_buf = '{P_MASK, 8'h00, 8'h11};
    send_packet(1'b1, 1'b0);
    pkt_buf = '{8'h00, 8'h00, 8'hFF, 8'h00};
    send_packet(1'b1, 1'b0);
  endtask

  task automatic test_short_packets();
    pkt_buf = '{P_MASK, 8'h00, 8'h01};
    send_packet(1'b0, 1'b0);
    pkt_buf = '{8'hFF, 8'hFF};
    send_packet(1'b1, 1'b0);
    pkt_buf = '{P_MASK};
    send_packet(1'b1, 1'b0);
    pkt_buf = '{P_MASK | V_MASK, 8'h00};
    send_packet(1'b1, 1'b0);
    pkt_buf = '{8'h00, 8'h00, 8'h02};
    send_packet(1'b1, 1'b0);
  endtask

  task automatic test_discontinuity();
    pkt_buf = '{P_MASK, 8'h00, 8'h33};
    send_packet(1'b0, 1'b0);
    pkt_buf = '{8'h00, 8'h00, 8'h44};
    send_packet(1'b1, 1'b1);
    pkt_buf = '{P_MASK, 8'h00};
    send_packet(1'b1, 1'b1);
    pkt_buf = '{P_MASK | V_MASK, 8'h00, 8'h5A, 8'h77};
    send_packet(1'b1, 1'b0);
  endtask

  task automatic test_packet_marks();
    send_byte(payload_byte(P_MASK, 1'b1, 1'b0, 1'b0, 1'b0));
    send_byte(payload_byte(8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    send_byte(payload_byte(8'h30, 1'b0, 1'b1, 1'b1, 1'b0));
    // The next packet arrives without its first mark.
    send_byte(payload_byte(8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    send_byte(payload_byte(8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    send_byte(payload_byte(8'h21, 1'b0, 1'b1, 1'b1, 1'b0));
    // A first mark in mid-packet restarts the header parse.
    send_byte(payload_byte(P_MASK, 1'b1, 1'b0, 1'b0, 1'b0));
    send_byte(payload_byte(8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    send_byte(payload_byte(8'h00, 1'b1, 1'b0, 1'b0, 1'b0));
    send_byte(payload_byte(8'h08, 1'b0, 1'b0, 1'b0, 1'b0));
    send_byte(payload_byte(8'h55, 1'b0, 1'b0, 1'b0, 1'b0));
    send_byte(payload_byte(8'h66, 1'b0, 1'b1, 1'b1, 1'b0));
  endtask

  task automatic test_drain_pause();
    send_byte(payload_byte(P_MASK, 1'b1, 1'b0, 1'b0, 1'b0));
    send_byte(payload_byte(8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    send_byte(payload_byte(8'h12, 1'b0, 1'b0, 1'b0, 1'b0));
    drain_results();
    send_byte(payload_byte(8'h34, 1'b0, 1'b1, 1'b1, 1'b0));
    drain_results();
  endtask

  // Mostly well-formed packets with random headers and bodies, the rest
  // truncated packets and loose bytes with random marks.
  task automatic test_random_traffic();
    int start_count;
    int hdr_extra;
    int total;
    logic p_bit;
    logic v_bit;
    logic [5:0] plen_v;
    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      stall_pct = (bytes_sent - start_count < CALM_BYTES) ? 0 : IDLE_PCT;
      if ($urandom_range(99) < 75) begin
        p_bit = $urandom_range(99) < 60;
        v_bit = 1'($urandom);
        plen_v = ($urandom_range(15) == 0) ? 6'($urandom_range(32, 40))
                                           : 6'($urandom_range(3));
        hdr_extra = int'(v_bit) + int'(plen_v);
        total = 2 + hdr_extra + $urandom_range(6);
        if ($urandom_range(9) == 0) begin
          total = $urandom_range(1, 2 + hdr_extra);
        end
        pkt_buf.delete();
        pkt_buf.push_back({5'($urandom), p_bit, v_bit, plen_v[5]});
        if (total > 1) begin
          pkt_buf.push_back({plen_v[4:0], 3'($urandom)});
        end
        while (pkt_buf.size() < total) begin
          pkt_buf.push_back(8'($urandom));
        end
        send_packet($urandom_range(99) < 60, $urandom_range(99) < 12);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_byte(rhp_in_t'(12'($urandom)));
        end
      end
    end
    stall_pct = IDLE_PCT;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      if (result_valid && result_ready) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          flag_mismatch("unexpected result, event_kind", result.event_kind, -1);
        end else begin
          oldest = expected_results.pop_front();
          if (result.event_kind !== oldest.event_kind)
            flag_mismatch("event_kind", result.event_kind, oldest.event_kind);
          if (result.out_byte !== oldest.out_byte)
            flag_mismatch("out_byte", result.out_byte, oldest.out_byte);
          if (result.frame_length !== oldest.frame_length)
            flag_mismatch("frame_length", result.frame_length, oldest.frame_length);
          if (result.frame_overflow !== oldest.frame_overflow)
            flag_mismatch("frame_overflow", result.frame_overflow, oldest.frame_overflow);
          if (result.run_last !== oldest.run_last)
            flag_mismatch("run_last", result.run_last, oldest.run_last);
          if (oldest.event_kind == KIND_DONE) begin
            commits_seen++;
            if (oldest.frame_overflow) saturated_commits++;
          end
          if (oldest.event_kind == KIND_DISCARD) discards_seen++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Stalled for %0d cycles with %0d results outstanding",
             QUIET_LIMIT, expected_results.size());
    $display("rtp_h263p_payload_depacketizer_core regression: fail");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_waiting_drop();
    test_short_packets();
    test_discontinuity();
    test_packet_marks();
    test_drain_pause();
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      flag_mismatch("results left undelivered", 0, expected_results.size());
    end
    $display("Checked %0d results from %0d payload bytes: %0d frame commits",
             results_checked, bytes_sent, commits_seen);
    $display("(%0d saturated), %0d discards.", saturated_commits, discards_seen);
    $display("Covered header skipping, waiting drop, short packets, missing marks and stalls.");
    if (mismatches == 0) begin
      $display("rtp_h263p_payload_depacketizer_core regression: pass");
    end else begin
      $display("rtp_h263p_payload_depacketizer_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/rhp_pkg.sv
rtl/core/rhp_front.sv
rtl/core/rhp_queue.sv
rtl/core/rhp_back.sv
rtl/core/rtp_h263p_payload_depacketizer_core.sv
tb/sv/rtp_h263p_payload_depacketizer_core_tb.sv
